FILE: rtl/core/kmp_pkg.sv
// ----------------------------------------------------------------------------
// kmp_pkg
// Shared types, constants and helpers of the keyboard macro player.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MACRO_SLOTS    = 128;
    localparam int KEYS_PER_MACRO = 32;
    localparam int HELD_DEPTH     = 16;
    localparam int MAX_RESULTS    = 64;

    localparam int MI_W = $clog2(MACRO_SLOTS);
    localparam int KS_W = $clog2(KEYS_PER_MACRO) > 0 ? $clog2(KEYS_PER_MACRO) : 1;
    localparam int HD_W = $clog2(HELD_DEPTH) > 0 ? $clog2(HELD_DEPTH) : 1;
    localparam int HC_W = $clog2(HELD_DEPTH + 1);
    localparam int RC_W = $clog2(MAX_RESULTS + 1);
    localparam int KA_W = MI_W + KS_W;

    localparam logic [1:0] FUNC_HDR  = 2'd0;
    localparam logic [1:0] FUNC_SLOT = 2'd1;
    localparam logic [1:0] FUNC_KEY  = 2'd2;

    localparam logic [9:0] CODE_F13 = 10'd183;
    localparam logic [9:0] CODE_F16 = 10'd186;
    localparam logic [9:0] CODE_F17 = 10'd187;
    localparam logic [9:0] CODE_F22 = 10'd192;

    typedef struct packed {
        logic [1:0] func;
        logic [6:0] macro_index;
        logic [1:0] profile_number;
        logic [2:0] g_number;
        logic [5:0] used_slots;
        logic [4:0] key_slot;
        logic [9:0] key_code;
        logic       is_release;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [9:0] out_key;
        logic       pressed;
        logic [3:0] led_mask;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        EV_LED,
        EV_LED_REC,
        EV_KEY_DN,
        EV_KEY_UP,
        EV_POP
    } ev_t;

    typedef struct packed {
        logic load;
        logic hdr_wr;
        logic key_wr;
        logic set_prof;
        logic scan_clr;
        logic scan_rd;
        logic scan_inc;
        logic start_play;
        logic key_rd;
        logic peek_rd;
        logic j_inc;
        logic emit;
        ev_t  ev;
        logic push;
        logic pop;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic sel_prof;
        logic sel_rec;
        logic sel_play;
        logic hdr_match;
        logic scan_last;
        logic slot_mark;
        logic slot_mod;
        logic plain_chk;
        logic slots_done;
        logic held_zero;
        logic emit_ok;
        logic flush_ok;
    } sts_t;

    function automatic logic modifier_key(input logic [9:0] c);
        return c == 10'd29 || c == 10'd97 || c == 10'd42 || c == 10'd54 ||
               c == 10'd56 || c == 10'd100 || c == 10'd125 || c == 10'd126;
    endfunction

endpackage

FILE: rtl/core/kmp_ctrl.sv
// ----------------------------------------------------------------------------
// kmp_ctrl
// Sequencer of the macro player: decodes items, scans headers, walks slots.
// ----------------------------------------------------------------------------
module kmp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    input  logic [1:0]     item_func,
    output logic           item_ready,
    input  kmp_pkg::sts_t  sts,
    output kmp_pkg::cmd_t  cmd
);
    import kmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_LED_REC, S_LED, S_SCAN_RD, S_SCAN_CHK, S_SLOT_CHK,
        S_KEY_EVAL, S_KEY_UP, S_PEEK_EVAL, S_NEXT, S_REL, S_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   rel_end_reg, rel_end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rel_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rel_end_reg <= rel_end_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.ev       = EV_LED;
        state_next   = state_reg;
        rel_end_next = rel_end_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load = 1'b1;
                    if (item_func == FUNC_HDR)       cmd.hdr_wr = 1'b1;
                    else if (item_func == FUNC_SLOT) cmd.key_wr = 1'b1;
                    else if (item_func == FUNC_KEY)  state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                if (sts.sel_prof)
                begin
                    cmd.set_prof = 1'b1;
                    state_next   = S_LED;
                end
                else if (sts.sel_rec)
                    state_next = S_LED_REC;
                else if (sts.sel_play)
                begin
                    cmd.scan_clr = 1'b1;
                    state_next   = S_SCAN_RD;
                end
                else
                    state_next = S_IDLE;
            end
            S_LED_REC:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = EV_LED_REC;
                    state_next = S_LED;
                end
            end
            S_LED:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.ev     = EV_LED;
                    state_next = S_FLUSH;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (sts.hdr_match)
                begin
                    cmd.start_play = 1'b1;
                    state_next     = S_SLOT_CHK;
                end
                else if (sts.scan_last)
                    state_next = S_FLUSH;
                else
                begin
                    cmd.scan_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_SLOT_CHK:
            begin
                if (sts.slots_done)
                begin
                    rel_end_next = 1'b1;
                    state_next   = S_REL;
                end
                else
                begin
                    cmd.key_rd = 1'b1;
                    state_next = S_KEY_EVAL;
                end
            end
            S_KEY_EVAL:
            begin
                if (sts.slot_mark)
                begin
                    rel_end_next = 1'b0;
                    state_next   = S_REL;
                end
                else if (sts.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev   = EV_KEY_DN;
                    if (sts.slot_mod)
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_NEXT;
                    end
                    else
                        state_next = S_KEY_UP;
                end
            end
            S_KEY_UP:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev   = EV_KEY_UP;
                    if (sts.plain_chk)
                    begin
                        cmd.peek_rd = 1'b1;
                        state_next  = S_PEEK_EVAL;
                    end
                    else
                        state_next = S_NEXT;
                end
            end
            S_PEEK_EVAL:
            begin
                if (!sts.slot_mark && !sts.slot_mod)
                begin
                    rel_end_next = 1'b0;
                    state_next   = S_REL;
                end
                else
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                cmd.j_inc  = 1'b1;
                state_next = S_SLOT_CHK;
            end
            S_REL:
            begin
                if (sts.held_zero)
                    state_next = rel_end_reg ? S_FLUSH : S_NEXT;
                else if (sts.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev   = EV_POP;
                    cmd.pop  = 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (sts.flush_ok)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/kmp_dp.sv
// ----------------------------------------------------------------------------
// kmp_dp
// Datapath: macro tables, modifier stack, result staging and output register.
// ----------------------------------------------------------------------------
module kmp_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  kmp_pkg::item_t   item,
    input  kmp_pkg::cmd_t    cmd,
    output kmp_pkg::sts_t    sts,
    output logic             result_valid,
    input  logic             result_ready,
    output kmp_pkg::result_t result
);
    import kmp_pkg::*;

    item_t            item_reg;
    logic [1:0]       prof_reg;
    logic [MI_W-1:0]  scan_reg;
    logic [MI_W-1:0]  mi_reg;
    logic [MACRO_SLOTS-1:0] hv_reg;
    logic [10:0]      hdr_mem [MACRO_SLOTS];
    logic [10:0]      hdr_q_reg;
    logic             hv_q_reg;
    logic [10:0]      key_mem [MACRO_SLOTS*KEYS_PER_MACRO];
    logic [10:0]      key_q_reg;
    logic [5:0]       cnt_reg;
    logic [5:0]       j_reg;
    logic [9:0]       stack_reg [HELD_DEPTH];
    logic [HC_W-1:0]  held_reg;
    result_t          pend_reg, out_reg, ev_res;
    result_t          pend_fin;
    logic             pend_v_reg, out_v_reg;
    logic [RC_W-1:0]  rcnt_reg;

    logic [9:0]       code;
    logic [2:0]       g_target;
    logic [3:0]       pmask;
    logic [5:0]       j_plus;
    logic [HD_W-1:0]  top_idx;
    logic             out_free;
    logic             out_load;
    logic             can_store;
    logic             in_range;
    logic [KA_W-1:0]  wr_addr;
    logic [KA_W-1:0]  rd_addr;

    assign code     = item_reg.key_code;
    assign g_target = 3'(code - (CODE_F17 - 10'd1));
    assign j_plus   = j_reg + 6'd1;
    assign top_idx  = HD_W'(held_reg - 1'b1);
    assign out_free = !out_v_reg || result_ready;
    assign can_store = int'(rcnt_reg) < MAX_RESULTS;
    assign out_load = pend_v_reg && ((cmd.emit && can_store) || cmd.flush);
    assign in_range = int'(item.macro_index) < MACRO_SLOTS;
    assign wr_addr  = {item.macro_index[MI_W-1:0], item.key_slot[KS_W-1:0]};
    assign rd_addr  = cmd.peek_rd ? {mi_reg, j_plus[KS_W-1:0]}
                                  : {mi_reg, j_reg[KS_W-1:0]};

    always_comb
    begin
        unique case (prof_reg)
            2'd1:    pmask = 4'b0001;
            2'd2:    pmask = 4'b0010;
            2'd3:    pmask = 4'b0100;
            default: pmask = 4'b0000;
        endcase
    end

    always_comb
    begin
        pend_fin      = pend_reg;
        pend_fin.last = 1'b1;
    end

    always_comb
    begin
        ev_res = '0;
        unique case (cmd.ev)
            EV_LED:
            begin
                ev_res.kind     = 1'b1;
                ev_res.led_mask = pmask;
            end
            EV_LED_REC:
            begin
                ev_res.kind     = 1'b1;
                ev_res.led_mask = pmask | 4'b1000;
            end
            EV_KEY_DN:
            begin
                ev_res.out_key = key_q_reg[9:0];
                ev_res.pressed = 1'b1;
            end
            EV_KEY_UP: ev_res.out_key = key_q_reg[9:0];
            EV_POP:    ev_res.out_key = stack_reg[top_idx];
            default:   ev_res = '0;
        endcase
    end

    always_comb
    begin
        sts.sel_prof   = code >= CODE_F13 && code < CODE_F16;
        sts.sel_rec    = code == CODE_F16;
        sts.sel_play   = code >= CODE_F17 && code <= CODE_F22;
        sts.hdr_match  = hv_q_reg && hdr_q_reg[10:9] == prof_reg &&
                         hdr_q_reg[8:6] == g_target;
        sts.scan_last  = scan_reg == MI_W'(MACRO_SLOTS - 1);
        sts.slot_mark  = key_q_reg[10];
        sts.slot_mod   = modifier_key(key_q_reg[9:0]);
        sts.plain_chk  = held_reg != '0 && j_plus < cnt_reg;
        sts.slots_done = j_reg == cnt_reg;
        sts.held_zero  = held_reg == '0;
        sts.emit_ok    = !can_store || !pend_v_reg || out_free;
        sts.flush_ok   = !pend_v_reg || out_free;
    end

    // Memories: one write port, one registered read port each.
    always_ff @(posedge clk)
    begin
        if (cmd.hdr_wr && in_range)
            hdr_mem[item.macro_index[MI_W-1:0]] <=
                {item.profile_number, item.g_number, item.used_slots};
        if (cmd.scan_rd)
            hdr_q_reg <= hdr_mem[scan_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.key_wr && in_range && int'(item.key_slot) < KEYS_PER_MACRO)
            key_mem[wr_addr] <= {item.is_release, item.key_code};
        if (cmd.key_rd || cmd.peek_rd)
            key_q_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push && int'(held_reg) < HELD_DEPTH)
            stack_reg[held_reg[HD_W-1:0]] <= key_q_reg[9:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg   <= '0;
            prof_reg   <= 2'd1;
            scan_reg   <= '0;
            mi_reg     <= '0;
            hv_reg     <= '0;
            hv_q_reg   <= 1'b0;
            cnt_reg    <= '0;
            j_reg      <= '0;
            held_reg   <= '0;
            pend_reg   <= '0;
            out_reg    <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            rcnt_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                item_reg <= item;
                rcnt_reg <= '0;
            end
            if (cmd.hdr_wr && in_range)
                hv_reg[item.macro_index[MI_W-1:0]] <= item.used_slots != 6'd0;
            if (cmd.set_prof)
                prof_reg <= 2'(code - (CODE_F13 - 10'd1));
            if (cmd.scan_clr)
                scan_reg <= '0;
            else if (cmd.scan_inc)
                scan_reg <= scan_reg + 1'b1;
            if (cmd.scan_rd)
                hv_q_reg <= hv_reg[scan_reg];
            if (cmd.start_play)
            begin
                mi_reg   <= scan_reg;
                cnt_reg  <= (int'(hdr_q_reg[5:0]) > KEYS_PER_MACRO)
                            ? 6'(KEYS_PER_MACRO) : hdr_q_reg[5:0];
                j_reg    <= '0;
                held_reg <= '0;
            end
            else if (cmd.j_inc)
                j_reg <= j_plus;
            if (cmd.push && int'(held_reg) < HELD_DEPTH)
                held_reg <= held_reg + 1'b1;
            else if (cmd.pop)
                held_reg <= held_reg - 1'b1;

            // The newest result waits in the staging register, so the final
            // one can be marked when the item's work ends.
            if (out_load)
                out_v_reg <= 1'b1;
            else if (out_v_reg && result_ready)
                out_v_reg <= 1'b0;
            if (cmd.emit && can_store)
            begin
                if (pend_v_reg)
                    out_reg <= pend_reg;
                pend_reg   <= ev_res;
                pend_v_reg <= 1'b1;
                rcnt_reg   <= rcnt_reg + 1'b1;
            end
            else if (cmd.flush && pend_v_reg)
            begin
                out_reg    <= pend_fin;
                pend_v_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_v_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/core/keyboard_macro_player_top.sv
// ----------------------------------------------------------------------------
// keyboard_macro_player_top
// Keyboard macro engine: macro table loading, profile LEDs and macro replay.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A header or slot write is stored as it is
// accepted. A profile key (F13 to F15) or the record key (F16) yields one or
// two LED beats. A macro key (F17 to F22) first scans the header table, one
// header at a time through its registered read port, all of it when no macro
// matches, then walks the matching macro one slot read at a time while the
// result side keeps up: a modifier slot is pressed and held, a plain key is
// pressed and released and may look at the following slot, a release marker
// releases the held modifiers, and each released modifier gives one beat.
// At most 64 result beats are produced per item; the last carries the
// last flag. The next item is accepted as soon as the final beat has moved
// into the output register, even if the consumer has not taken it yet.
// Header valid bits clear at reset; key slots read before being written give
// undefined codes.
// ----------------------------------------------------------------------------
module keyboard_macro_player_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  kmp_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output kmp_pkg::result_t result
);
    import kmp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The sequencer owns all decisions; the datapath only executes commands.
    kmp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_func  (item.func),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Tables, the modifier stack and the two-deep result staging live here.
    kmp_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: rtl/core/kmp_checker.sv
// ----------------------------------------------------------------------------
// kmp_checker
// Port-level checks of the keyboard macro player, bound to the top level.
// ----------------------------------------------------------------------------
module kmp_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input kmp_pkg::result_t result
);
    import kmp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result beat dropped or changed while stalled");

    a_led_profile: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind |->
            $onehot(result.led_mask[2:0]) && result.out_key == '0)
        else $error("LED beat without a single profile bit");

    a_key_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.kind |-> result.led_mask == 4'd0)
        else $error("key beat carries an LED mask");

endmodule

bind keyboard_macro_player_top kmp_checker u_kmp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

FILE: tb/keyboard_macro_player_top_tb.sv
// ----------------------------------------------------------------------------
// keyboard_macro_player_top_tb
// Self-checking testbench of the keyboard macro player.
// ----------------------------------------------------------------------------
// Load beats build a macro table, and key press beats select profiles, pulse
// the record LED and replay macros. A scoreboard class keeps its own copy of
// the table, the profile and the modifier stack. It predicts the result beats
// of every accepted item and compares each result beat with the oldest
// prediction. Both sides stall at random, and the result side holds off once
// for a long stretch so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyboard_macro_player_top_tb;

    import kmp_pkg::*;

    // The unused function code is ignored by the block.
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam logic [9:0] CODE_F14  = 10'd184;
    localparam logic [9:0] CODE_F15  = 10'd185;
    localparam int         N_ITEMS   = 180;
    localparam longint     LIMIT     = 2_000_000;

    // ------------------------------------------------------------------------
    // Scoreboard: a cycle-free model of the macro engine plus the queue of
    // result beats still to come.
    // ------------------------------------------------------------------------
    class macro_scoreboard;
        logic [1:0] profile;
        logic       hdr_valid [MACRO_SLOTS];
        logic [1:0] hdr_prof [MACRO_SLOTS];
        logic [2:0] hdr_g [MACRO_SLOTS];
        logic [5:0] hdr_cnt [MACRO_SLOTS];
        logic [10:0] slots [MACRO_SLOTS][KEYS_PER_MACRO];
        logic [9:0] held [HELD_DEPTH];
        int         held_n;
        int         beat_n;
        int         errors;
        result_t    expected_beats [$];

        function new();
            profile = 2'd1;
            held_n  = 0;
            errors  = 0;
            for (int i = 0; i < MACRO_SLOTS; i++)
            begin
                hdr_valid[i] = 1'b0;
            end
        endfunction

        function bit modifier(logic [9:0] c);
            return c == 10'd29 || c == 10'd97 || c == 10'd42 || c == 10'd54 ||
                   c == 10'd56 || c == 10'd100 || c == 10'd125 || c == 10'd126;
        endfunction

        function void push_beat(bit kind, logic [9:0] key, bit dn, logic [3:0] mask);
            result_t r;
            if (beat_n >= MAX_RESULTS) return;
            r = '{kind: kind, out_key: key, pressed: dn, led_mask: mask, last: 1'b0};
            expected_beats.push_back(r);
            beat_n++;
        endfunction

        function void release_held();
            while (held_n > 0)
            begin
                held_n--;
                push_beat(1'b0, held[held_n], 1'b0, 4'd0);
            end
        endfunction

        function logic [3:0] led_bits();
            return (profile == 2'd0) ? 4'd0 : 4'(1 << (profile - 1));
        endfunction

        // Replays the first valid macro of the current profile bound to g.
        function void play_macro(logic [2:0] g);
            int cnt;
            logic [10:0] s;
            logic [10:0] nx;
            for (int i = 0; i < MACRO_SLOTS; i++)
            begin
                if (!hdr_valid[i] || hdr_prof[i] != profile || hdr_g[i] != g) continue;
                cnt    = (hdr_cnt[i] > KEYS_PER_MACRO) ? KEYS_PER_MACRO : hdr_cnt[i];
                held_n = 0;
                for (int j = 0; j < cnt; j++)
                begin
                    s = slots[i][j];
                    if (s[10])
                    begin
                        release_held();
                    end
                    else if (modifier(s[9:0]))
                    begin
                        push_beat(1'b0, s[9:0], 1'b1, 4'd0);
                        if (held_n < HELD_DEPTH)
                        begin
                            held[held_n] = s[9:0];
                            held_n++;
                        end
                    end
                    else
                    begin
                        push_beat(1'b0, s[9:0], 1'b1, 4'd0);
                        push_beat(1'b0, s[9:0], 1'b0, 4'd0);
                        // Smart auto-release before a following plain key.
                        if (held_n > 0 && j + 1 < cnt)
                        begin
                            nx = slots[i][j + 1];
                            if (!nx[10] && !modifier(nx[9:0])) release_held();
                        end
                    end
                end
                release_held();
                return;
            end
        endfunction

        function void note_item(item_t it);
            int before_n;
            before_n = expected_beats.size();
            beat_n   = 0;
            case (it.func)
                FUNC_HDR:
                begin
                    hdr_valid[it.macro_index] = it.used_slots != 0;
                    hdr_prof[it.macro_index]  = it.profile_number;
                    hdr_g[it.macro_index]     = it.g_number;
                    hdr_cnt[it.macro_index]   = it.used_slots;
                end
                FUNC_SLOT: slots[it.macro_index][it.key_slot] = {it.is_release, it.key_code};
                FUNC_KEY:
                begin
                    if (it.key_code >= CODE_F13 && it.key_code < CODE_F16)
                    begin
                        profile = 2'(it.key_code - CODE_F13 + 1);
                        push_beat(1'b1, 10'd0, 1'b0, led_bits());
                    end
                    else if (it.key_code == CODE_F16)
                    begin
                        push_beat(1'b1, 10'd0, 1'b0, led_bits() | 4'd8);
                        push_beat(1'b1, 10'd0, 1'b0, led_bits());
                    end
                    else if (it.key_code >= CODE_F17 && it.key_code <= CODE_F22)
                    begin
                        play_macro(3'(it.key_code - CODE_F17 + 1));
                    end
                end
                default: ;
            endcase
            if (expected_beats.size() > before_n) expected_beats[$].last = 1'b1;
        endfunction

        function void check_beat(result_t got);
            result_t exp_r;
            if (expected_beats.size() == 0)
            begin
                $error("result beat %p arrived with nothing expected", got);
                errors++;
                return;
            end
            exp_r = expected_beats.pop_front();
            if (got.kind !== exp_r.kind)
            begin
                $error("kind: expected %0d, got %0d", exp_r.kind, got.kind);
                errors++;
            end
            if (got.out_key !== exp_r.out_key)
            begin
                $error("out_key: expected %0d, got %0d", exp_r.out_key, got.out_key);
                errors++;
            end
            if (got.pressed !== exp_r.pressed)
            begin
                $error("pressed: expected %0d, got %0d", exp_r.pressed, got.pressed);
                errors++;
            end
            if (got.led_mask !== exp_r.led_mask)
            begin
                $error("led_mask: expected %0d, got %0d", exp_r.led_mask, got.led_mask);
                errors++;
            end
            if (got.last !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    macro_scoreboard sb = new();
    longint cycles = 0;
    int     items_sent = 0;
    int     beats_seen = 0;
    bit     quiet_send = 0;
    bit     quiet_recv = 0;

    keyboard_macro_player_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Every accepted result beat goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            sb.check_beat(result);
            beats_seen <= beats_seen + 1;
        end
    end

    // Result side: a random stall before each beat, stall-free phases, and one
    // long hold-off once the traffic is under way so the block fills up.
    initial
    begin
        int stall;
        bit held_off;
        held_off = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 29) == 0) quiet_recv = !quiet_recv;
            stall = quiet_recv ? 0 : $urandom_range(0, 12);
            if (!held_off && beats_seen >= 30)
            begin
                held_off = 1;
                stall    = 600;
            end
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
            do @(posedge clk); while (!result_valid);
        end
    end

    // Offers one beat and returns at the edge where it is accepted. Valid stays
    // high across back-to-back beats so it is never lowered and raised at once.
    task automatic send_item(item_t it);
        int gap;
        if ($urandom_range(0, 19) == 0) quiet_send = !quiet_send;
        gap = quiet_send ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic press_key(logic [9:0] code);
        item_t it;
        it          = item_t'($urandom());
        it.func     = FUNC_KEY;
        it.key_code = code;
        send_item(it);
    endtask

    // Slot content: mostly modifiers and plain keys, some release markers.
    function automatic logic [10:0] random_slot(int mod_pct);
        logic [9:0] mods [8] = '{10'd29, 10'd97, 10'd42, 10'd54,
                                 10'd56, 10'd100, 10'd125, 10'd126};
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < mod_pct) return {1'b0, mods[$urandom_range(0, 7)]};
        if (pick < mod_pct + 15) return {1'b1, 10'($urandom_range(0, 767))};
        return {1'b0, 10'($urandom_range(0, 767))};
    endfunction

    // Writes every slot the header will use, then the header itself, so a
    // replay never reads a slot that was never written.
    task automatic define_macro(int idx, int prof, int g, int cnt, int mod_pct);
        item_t it;
        logic [10:0] s;
        for (int j = 0; j < cnt && j < KEYS_PER_MACRO; j++)
        begin
            s              = random_slot(mod_pct);
            it             = item_t'($urandom());
            it.func        = FUNC_SLOT;
            it.macro_index = 7'(idx);
            it.key_slot    = 5'(j);
            it.is_release  = s[10];
            it.key_code    = s[9:0];
            send_item(it);
        end
        it                = item_t'($urandom());
        it.func           = FUNC_HDR;
        it.macro_index    = 7'(idx);
        it.profile_number = 2'(prof);
        it.g_number       = 3'(g);
        it.used_slots     = 6'(cnt);
        send_item(it);
    endtask

    // A header that can never be replayed: count zero, profile zero or a G
    // number outside one to six.
    task automatic dead_header();
        item_t it;
        it             = item_t'($urandom());
        it.func        = FUNC_HDR;
        it.macro_index = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 2))
            0: it.used_slots = 6'd0;
            1: it.profile_number = 2'd0;
            default: it.g_number = $urandom_range(0, 1) ? 3'd0 : 3'd7;
        endcase
        send_item(it);
    endtask

    initial
    begin
        item_t it;
        int pick;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: LED keys, keys that do nothing, the unused function
        // code, an empty table lookup and the corner cases of replay.
        press_key(CODE_F16);
        press_key(CODE_F14);
        press_key(CODE_F15);
        press_key(CODE_F16);
        press_key(CODE_F13);
        press_key(CODE_F17);
        press_key(10'd0);
        press_key(10'd767);
        it      = item_t'($urandom());
        it.func = FUNC_NONE;
        send_item(it);
        dead_header();
        dead_header();
        dead_header();
        define_macro(0, 1, 1, 4, 50);
        define_macro(127, 1, 6, 3, 40);
        press_key(CODE_F17);
        press_key(CODE_F22);
        // More than sixteen modifiers: the extra ones are never released.
        define_macro(5, 1, 2, 20, 100);
        press_key(10'd188);
        // A count above the slot limit replays only the first 32 slots.
        define_macro(9, 2, 3, 63, 30);
        press_key(CODE_F14);
        press_key(10'd189);
        press_key(CODE_F13);

        // Random part: mostly table loads followed by replays, with some noise.
        while (items_sent < N_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                press_key(10'($urandom_range(CODE_F17, CODE_F22)));
            end
            else if (pick < 45)
            begin
                press_key(10'($urandom_range(CODE_F13, CODE_F16)));
            end
            else if (pick < 65)
            begin
                define_macro($urandom_range(0, 127), $urandom_range(1, 3),
                             $urandom_range(1, 6),
                             ($urandom_range(0, 9) == 0) ? $urandom_range(20, 32)
                                                         : $urandom_range(1, 8),
                             $urandom_range(20, 60));
            end
            else if (pick < 75)
            begin
                it          = item_t'($urandom());
                it.func     = FUNC_SLOT;
                it.key_code = 10'($urandom_range(0, 767));
                send_item(it);
            end
            else if (pick < 85)
            begin
                dead_header();
            end
            else if (pick < 90)
            begin
                it      = item_t'($urandom());
                it.func = FUNC_NONE;
                send_item(it);
            end
            else
            begin
                press_key(10'($urandom_range(0, 767)));
            end
        end
        item_valid <= 1'b0;

        while (sb.expected_beats.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/kmp_pkg.sv
rtl/core/kmp_ctrl.sv
rtl/core/kmp_dp.sv
rtl/core/keyboard_macro_player_top.sv
rtl/core/kmp_checker.sv
tb/keyboard_macro_player_top_tb.sv
